// File: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define TSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold.
`define TSS_NEVER(label, cond, msg) \
  `TSS_ASSERT(label, !(cond), msg)

`endif

// File: rtl/tss_pkg.sv
package tss_pkg;

  localparam logic CMD_BEACON = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PERIOD = 1'd1;

  localparam logic [3:0]  NODE_ID_RESET     = 4'd1;
  localparam logic [15:0] AUTO_PERIOD_RESET = 16'd3000;

  // slot index times slot length, up to 17 * 65535
  localparam int OFF_W = 21;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] slot_len_ms;
    logic [15:0] cycle_len_ms;
    logic [15:0] sched_mask;
    logic        fleet_sleep;
    logic [15:0] per_node_sleep;
    logic [8:0]  jitter_ms;
  } tss_in_t;

  typedef struct packed {
    logic       transmit;
    logic       ack_sleep;
    logic       sleep_request;
    logic       in_sync;
    logic [4:0] slot_index;
  } tss_out_t;

  // classified word between front and back
  typedef struct packed {
    logic        is_tick;
    logic [15:0] slot_len;
    logic [15:0] cycle_len;
    logic [4:0]  rank;
    logic        sleep_me;
    logic [8:0]  jitter;
  } tss_item_t;

endpackage

// File: rtl/tss_front.sv
module tss_front #(
  parameter int MASK_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         node_id,
  input  logic               in_valid,
  output logic               in_stall,
  input  tss_pkg::tss_in_t   in_data,
  output logic               push,
  input  logic               q_full,
  output tss_pkg::tss_item_t item
);
  import tss_pkg::*;

  logic        f_valid;
  tss_item_t   f_item;
  tss_item_t   f_item_next;
  logic [15:0] below;
  logic        in_take;

  assign in_stall = f_valid && q_full;
  assign in_take  = in_valid && !in_stall;
  assign push     = f_valid && !q_full;
  assign item     = f_item;

  always_comb begin
    below = in_data.sched_mask & ((16'd1 << node_id) - 16'd1);
    f_item_next.is_tick   = (in_data.cmd == CMD_TICK);
    f_item_next.slot_len  = in_data.slot_len_ms;
    f_item_next.cycle_len = in_data.cycle_len_ms;
    f_item_next.jitter    = in_data.jitter_ms;
    f_item_next.sleep_me  = in_data.fleet_sleep || in_data.per_node_sleep[node_id];
    // one-based rank among set mask bits; bits above the node never count
    if ((32'(node_id) < MASK_BITS) && in_data.sched_mask[node_id]) begin
      f_item_next.rank = 5'($countones(below)) + 5'd1;
    end else begin
      f_item_next.rank = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_take) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (in_take) begin
      f_item <= f_item_next;
    end
  end

endmodule

// File: rtl/tss_queue.sv
module tss_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tss_pkg::tss_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output tss_pkg::tss_item_t head
);
  import tss_pkg::*;

  tss_item_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;

  assign full    = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/tss_back.sv
module tss_back #(
  parameter int LOST_CYCLES = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        auto_period_ms,
  input  logic               q_valid,
  input  tss_pkg::tss_item_t item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tss_pkg::tss_out_t  out_data
);
  import tss_pkg::*;

  localparam int LT_W = 16 + $clog2(LOST_CYCLES + 1);

  logic [31:0]      now_ms, now_ms_next;
  logic             sync_flag, sync_flag_next;
  logic [31:0]      beacon_time, beacon_time_next;
  logic [31:0]      last_auto_time, last_auto_time_next;
  logic [15:0]      cycle_len, cycle_len_next;
  logic [4:0]       my_slot, my_slot_next;
  logic             sent_this_cycle, sent_this_cycle_next;
  logic             pending_ack, pending_ack_next;
  logic             halted, halted_next;
  logic [OFF_W-1:0] slot_off, slot_off_next;
  logic [OFF_W-1:0] slot_end, slot_end_next;
  logic [LT_W-1:0]  lost_lim, lost_lim_next;

  logic [31:0] now1;
  logic [31:0] d_bt;
  logic [31:0] d_auto;
  logic        fits;
  logic        tx;
  logic        ack;
  tss_out_t    res;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    now_ms_next          = now_ms;
    sync_flag_next       = sync_flag;
    beacon_time_next     = beacon_time;
    last_auto_time_next  = last_auto_time;
    cycle_len_next       = cycle_len;
    my_slot_next         = my_slot;
    sent_this_cycle_next = sent_this_cycle;
    pending_ack_next     = pending_ack;
    halted_next          = halted;
    slot_off_next        = slot_off;
    slot_end_next        = slot_end;
    lost_lim_next        = lost_lim;
    res                  = '0;
    tx                   = 1'b0;
    ack                  = 1'b0;

    now1   = now_ms + 32'd1;
    d_bt   = now1 - beacon_time;
    d_auto = now1 - last_auto_time;
    fits   = (my_slot != 5'd0) && (slot_end <= OFF_W'(cycle_len));

    if (halted) begin
      res.sleep_request = 1'b1;
    end else if (!item.is_tick) begin
      beacon_time_next     = now_ms;
      cycle_len_next       = item.cycle_len;
      my_slot_next         = item.rank;
      sync_flag_next       = 1'b1;
      sent_this_cycle_next = 1'b0;
      pending_ack_next     = item.sleep_me;
      // slot window is fixed per beacon, so the products are kept
      slot_off_next = OFF_W'(item.rank) * OFF_W'(item.slot_len);
      slot_end_next = OFF_W'(item.rank + 5'd1) * OFF_W'(item.slot_len);
      lost_lim_next = LT_W'(LOST_CYCLES) * LT_W'(item.cycle_len);
    end else begin
      now_ms_next = now1;
      if (sync_flag) begin
        if (fits) begin
          if (!sent_this_cycle && (d_bt >= 32'(slot_off))) begin
            tx = 1'b1;
            ack = pending_ack;
            sent_this_cycle_next = 1'b1;
          end
        end else if (d_auto > (32'(cycle_len) + 32'(item.jitter))) begin
          // join transmit
          tx = 1'b1;
          ack = pending_ack;
          last_auto_time_next = now1;
        end
        if (ack) begin
          res.sleep_request = 1'b1;
          halted_next = 1'b1;
        end else if (d_bt > 32'(lost_lim)) begin
          sync_flag_next = 1'b0;
        end
      end else if (d_auto > (32'(auto_period_ms) + 32'(item.jitter))) begin
        tx = 1'b1;
        last_auto_time_next = now1;
      end
    end

    res.transmit   = tx;
    res.ack_sleep  = ack;
    res.in_sync    = sync_flag_next;
    res.slot_index = my_slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      now_ms          <= '0;
      sync_flag       <= 1'b0;
      beacon_time     <= '0;
      last_auto_time  <= '0;
      cycle_len       <= '0;
      my_slot         <= '0;
      sent_this_cycle <= 1'b0;
      pending_ack     <= 1'b0;
      halted          <= 1'b0;
      slot_off        <= '0;
      slot_end        <= '0;
      lost_lim        <= '0;
    end else begin
      if (pop) begin
        out_valid       <= 1'b1;
        now_ms          <= now_ms_next;
        sync_flag       <= sync_flag_next;
        beacon_time     <= beacon_time_next;
        last_auto_time  <= last_auto_time_next;
        cycle_len       <= cycle_len_next;
        my_slot         <= my_slot_next;
        sent_this_cycle <= sent_this_cycle_next;
        pending_ack     <= pending_ack_next;
        halted          <= halted_next;
        slot_off        <= slot_off_next;
        slot_end        <= slot_end_next;
        lost_lim        <= lost_lim_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      out_data <= res;
    end
  end

endmodule

// File: rtl/tdma_slot_transmit_scheduler.sv
// TDMA slot transmit scheduler: one result word per beacon or tick word.
// A taken word passes the front register, the queue and the output register in turn.
// One word per cycle unless the queue fills or out_stall holds the output register.
// Reset (rst, synchronous): clears all timing and sync state and the halt,
// and sets node_id to 1 and auto_period_ms to 3000.
`include "assert_macros.svh"

module tdma_slot_transmit_scheduler #(
  parameter int MASK_BITS   = 16,
  parameter int LOST_CYCLES = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tss_pkg::tss_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tss_pkg::tss_out_t                out_data
);
  import tss_pkg::*;

  logic [3:0]  node_id;
  logic [15:0] auto_period_ms;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  tss_item_t   f_item;
  tss_item_t   q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id        <= NODE_ID_RESET;
      auto_period_ms <= AUTO_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID:     node_id        <= cfg_data[3:0];
        CFG_AUTO_PERIOD: auto_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  tss_front #(
    .MASK_BITS(MASK_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .node_id  (node_id),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .q_full   (q_full),
    .item     (f_item)
  );

  tss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  tss_back #(
    .LOST_CYCLES(LOST_CYCLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .auto_period_ms (auto_period_ms),
    .q_valid        (q_valid),
    .item           (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

  // a sleep acknowledge only rides on a synced transmit
  `TSS_ASSERT(a_ack_tx, out_valid && out_data.ack_sleep |-> out_data.transmit && out_data.sleep_request && out_data.in_sync, "ack_sleep without synced transmit")
  // halted words never transmit
  `TSS_NEVER(a_halt_quiet, out_valid && out_data.sleep_request && !out_data.ack_sleep && out_data.transmit, "transmit while halted")
  // the back end only pulls a word when the output register can take it
  `TSS_NEVER(a_pop_stall, pop && out_valid && out_stall, "result overwritten while stalled")

endmodule

// File: tb/tb_tdma_slot_transmit_scheduler.sv
module tb_tdma_slot_transmit_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import tss_pkg::*;

  localparam logic [31:0] LOST_CYCLES = 32'd3;
  localparam int          IDLE_LIMIT  = 5000;
  localparam int          WORDS_PER_PHASE = 150;

  typedef struct {
    tss_in_t  w;
    bit       typed;
    tss_out_t want;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  tss_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  tss_out_t             out_data;

  tdma_slot_transmit_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // scheduler state as the testbench sees it
  logic [3:0]  node_id_q;
  logic [15:0] auto_period_q;
  logic [31:0] ms_clk;
  logic        synced;
  logic [31:0] bcn_time;
  logic [31:0] last_bcn;
  logic [31:0] last_tx_auto;
  logic [15:0] slot_len_q;
  logic [15:0] cycle_len_q;
  logic [4:0]  my_slot_q;
  logic        sent_flag;
  logic        ack_pending;
  logic        halted_st;

  tss_out_t tx_decisions_q[$];
  dir_row_t dir_rows[$];

  int          n_err;
  int          idle_cyc;
  int          stall_hold;
  logic [31:0] cyc;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] slot_rank(logic [15:0] mask, logic [3:0] id);
    logic [4:0] cnt;
    cnt = '0;
    if (!mask[id]) return 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (i < id) cnt += 5'(mask[i]);
    end
    return cnt + 5'd1;
  endfunction

  function tss_out_t schedule_word(tss_in_t w);
    tss_out_t    r;
    logic [31:0] off;
    logic [31:0] jit;
    r = '0;
    if (halted_st) begin
      r.sleep_request = 1'b1;
    end else if (w.cmd == CMD_BEACON) begin
      bcn_time    = ms_clk;
      last_bcn    = ms_clk;
      slot_len_q  = w.slot_len_ms;
      cycle_len_q = w.cycle_len_ms;
      my_slot_q   = slot_rank(w.sched_mask, node_id_q);
      synced      = 1'b1;
      sent_flag   = 1'b0;
      ack_pending = w.fleet_sleep | w.per_node_sleep[node_id_q];
    end else begin
      jit = 32'(w.jitter_ms);
      ms_clk = ms_clk + 32'd1;
      if (synced) begin
        off = 32'(my_slot_q) * 32'(slot_len_q);
        if (my_slot_q != 5'd0 && off + 32'(slot_len_q) <= 32'(cycle_len_q)) begin
          if (!sent_flag && ms_clk - bcn_time >= off) begin
            r.transmit  = 1'b1;
            r.ack_sleep = ack_pending;
            sent_flag   = 1'b1;
          end
        end else if (ms_clk - last_tx_auto > 32'(cycle_len_q) + jit) begin
          // join transmit when the slot does not fit the cycle
          r.transmit   = 1'b1;
          r.ack_sleep  = ack_pending;
          last_tx_auto = ms_clk;
        end
        if (r.ack_sleep) begin
          r.sleep_request = 1'b1;
          halted_st       = 1'b1;
        end else if (ms_clk - last_bcn > LOST_CYCLES * 32'(cycle_len_q)) begin
          synced = 1'b0;
        end
      end else if (ms_clk - last_tx_auto > 32'(auto_period_q) + jit) begin
        r.transmit   = 1'b1;
        last_tx_auto = ms_clk;
      end
    end
    r.in_sync    = synced;
    r.slot_index = my_slot_q;
    return r;
  endfunction

  function automatic tss_in_t beacon(logic [15:0] sl, logic [15:0] cl, logic [15:0] mask,
                                     logic fleet, logic [15:0] pns);
    tss_in_t w;
    w = '0;
    w.cmd            = CMD_BEACON;
    w.slot_len_ms    = sl;
    w.cycle_len_ms   = cl;
    w.sched_mask     = mask;
    w.fleet_sleep    = fleet;
    w.per_node_sleep = pns;
    return w;
  endfunction

  function automatic tss_in_t tick(logic [8:0] jit);
    tss_in_t w;
    w = '0;
    w.cmd       = CMD_TICK;
    w.jitter_ms = jit;
    return w;
  endfunction

  function automatic tss_out_t outw(logic tx, logic ack, logic sreq, logic sync,
                                    logic [4:0] slot);
    return {tx, ack, sreq, sync, slot};
  endfunction

  function automatic void check_field(string name, logic [4:0] want, logic [4:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  // result side: compare each taken word with the oldest prediction
  always @(posedge clk) begin
    tss_out_t want;
    if (rst) begin
      idle_cyc <= 0;
      cyc      <= '0;
    end else begin
      cyc <= cyc + 32'd1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (tx_decisions_q.size() == 0) begin
          $error("result word with no prediction waiting: %h", out_data);
          n_err++;
        end else begin
          want = tx_decisions_q.pop_front();
          check_field("transmit", 5'(want.transmit), 5'(out_data.transmit));
          check_field("ack_sleep", 5'(want.ack_sleep), 5'(out_data.ack_sleep));
          check_field("sleep_request", 5'(want.sleep_request), 5'(out_data.sleep_request));
          check_field("in_sync", 5'(want.in_sync), 5'(out_data.in_sync));
          check_field("slot_index", want.slot_index, out_data.slot_index);
        end
      end
    end
  end

  // result stall: mostly short, a few long, quiet windows with none
  always @(negedge clk) begin
    int r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (cyc[9:8] == 2'b11 || r < 70) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 4);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
      end
    end
  end

  task automatic send_word(tss_in_t w, bit typed = 1'b0, tss_out_t want = '0);
    int       gap;
    tss_out_t pred;
    if (cyc[9:8] == 2'b01) gap = 0;
    else gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 20);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    pred = schedule_word(w);
    tx_decisions_q.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tx_decisions_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_NODE_ID) node_id_q = val[3:0];
    else if (idx == CFG_AUTO_PERIOD) auto_period_q = val;
  endtask

  task automatic set_config(logic [3:0] id, logic [15:0] period);
    // upper bits of the node word are don't-care
    cfg_write(CFG_NODE_ID, {12'($urandom), id});
    cfg_write(CFG_AUTO_PERIOD, period);
  endtask

  function automatic logic [8:0] rand_jitter();
    return ($urandom_range(0, 9) < 6) ? 9'($urandom_range(0, 40)) : 9'($urandom);
  endfunction

  // random words, or a beacon followed by a run of ticks; sleep bits kept clear for this node
  task automatic run_traffic(int n_words);
    int      sent;
    int      run;
    tss_in_t w;
    logic [15:0] sl, cl, pns;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 15) begin
        w = tss_in_t'({$urandom, $urandom, $urandom});
        w.fleet_sleep = 1'b0;
        w.per_node_sleep[node_id_q] = 1'b0;
        send_word(w);
        sent++;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          sl = 16'($urandom);
          cl = 16'($urandom);
        end else begin
          sl = 16'($urandom_range(0, 12));
          cl = 16'($urandom_range(0, 120));
        end
        pns = 16'($urandom);
        pns[node_id_q] = 1'b0;
        w = beacon(sl, cl, 16'($urandom), 1'b0, pns);
        w.jitter_ms = 9'($urandom);
        send_word(w);
        sent++;
        run = $urandom_range(1, 60);
        repeat (run) begin
          w = tss_in_t'({$urandom, $urandom, $urandom});
          w.cmd       = CMD_TICK;
          w.jitter_ms = rand_jitter();
          send_word(w);
          sent++;
        end
      end
    end
  endtask

  initial begin
    tss_in_t     w;
    logic [15:0] mask;
    n_err         = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    node_id_q     = NODE_ID_RESET;
    auto_period_q = AUTO_PERIOD_RESET;
    ms_clk        = '0;
    synced        = 1'b0;
    bcn_time      = '0;
    last_bcn      = '0;
    last_tx_auto  = '0;
    slot_len_q    = '0;
    cycle_len_q   = '0;
    my_slot_q     = '0;
    sent_flag     = 1'b0;
    ack_pending   = 1'b0;
    halted_st     = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_config(4'd1, 16'd0);

    dir_rows.push_back('{tick(9'd0), 1'b1, outw(1, 0, 0, 0, 5'd0)});
    dir_rows.push_back('{tick(9'h1FF), 1'b1, outw(0, 0, 0, 0, 5'd0)});
    dir_rows.push_back('{beacon(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000), 1'b1,
                         outw(0, 0, 0, 1, 5'd2)});
    dir_rows.push_back('{tick(9'd0), 1'b0, '0});
    dir_rows.push_back('{beacon(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000), 1'b1,
                         outw(0, 0, 0, 1, 5'd0)});
    dir_rows.push_back('{tick(9'd0), 1'b0, '0});
    // slot 1 fits a two ms cycle; transmit once, then sync drops
    dir_rows.push_back('{beacon(16'd1, 16'd2, 16'h0002, 1'b0, 16'hFFFD), 1'b1,
                         outw(0, 0, 0, 1, 5'd1)});
    for (int i = 0; i < 7; i++) dir_rows.push_back('{tick(i[0] ? 9'h1FF : 9'd0), 1'b0, '0});
    // fleet sleep pending, then sync lost: autonomous transmit carries no ack
    dir_rows.push_back('{beacon(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000), 1'b1,
                         outw(0, 0, 0, 1, 5'd0)});
    dir_rows.push_back('{tick(9'h1FF), 1'b0, '0});
    dir_rows.push_back('{tick(9'd0), 1'b0, '0});
    dir_rows.push_back('{beacon(16'hFFFF, 16'h0000, 16'hFFFE, 1'b0, 16'h0001), 1'b1,
                         outw(0, 0, 0, 1, 5'd1)});
    dir_rows.push_back('{tick(9'h1FF), 1'b0, '0});
    dir_rows.push_back('{tick(9'h155), 1'b0, '0});

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    set_config(4'd15, 16'hFFFF);
    run_traffic(WORDS_PER_PHASE);
    drain_results();
    set_config(4'd7, 16'($urandom_range(0, 200)));
    run_traffic(WORDS_PER_PHASE);
    drain_results();
    set_config(4'($urandom_range(1, 15)), AUTO_PERIOD_RESET);
    run_traffic(WORDS_PER_PHASE);
    drain_results();
    set_config(4'd15, 16'd20);
    run_traffic(WORDS_PER_PHASE);
    drain_results();
    set_config(4'd1, 16'($urandom_range(0, 100)));
    run_traffic(WORDS_PER_PHASE);
    drain_results();
    set_config(4'($urandom_range(1, 15)), 16'd10);
    run_traffic(WORDS_PER_PHASE - 50);
    drain_results();

    // sleep command to this node in a slot that fits: ack, then halt
    mask = 16'($urandom);
    mask[node_id_q] = 1'b1;
    w = beacon(16'($urandom_range(1, 3)), 16'd60, mask, 1'($urandom), 16'($urandom));
    w.per_node_sleep[node_id_q] = 1'b1;
    send_word(w);
    repeat (60) send_word(tick(rand_jitter()));
    repeat (30) send_word(tss_in_t'({$urandom, $urandom, $urandom}));
    drain_results();

    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
